// ===== src/rakf_pkg.sv =====
// shared types, constants and helper functions of the roll angle kalman filter
package rakf_pkg;

  // fixed point configuration
  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int ATAN_LEN        = 24;

  // accelerometer offsets in units of 2^-20 g
  localparam logic [24:0] ACC_X_OFS = 25'd104858;
  localparam logic [24:0] ACC_Y_OFS = 25'd81789;
  localparam logic [24:0] ACC_Z_OFS = 25'd104858;

  // measured angle rounding from 2^-24 degree units
  localparam int MEAS_SHIFT = 24 - ANGLE_FRAC_BITS;
  localparam logic signed [31:0] MEAS_RND = 32'sd1 <<< (23 - ANGLE_FRAC_BITS);
  localparam logic signed [24:0] ANGLE_90 = 25'sd90 <<< ANGLE_FRAC_BITS;

  // gyro increment: round(n / (131 * 2^(23-F))) as a shift by 23-F bits, then
  // a multiply by ceil(2^39 / 131), exact for shifted values below 2^32
  localparam int GYRO_SHIFT = 23 - ANGLE_FRAC_BITS;
  localparam logic [40:0] GYRO_RND = 41'd131 << (GYRO_SHIFT - 1);
  localparam int GYRO_RCP_SHIFT = 39;
  localparam logic [31:0] GYRO_RCP = 32'd4196609267;

  // register indexes
  localparam logic [2:0] CFG_ROLL_OFFSET  = 3'd0;
  localparam logic [2:0] CFG_TIME_STEP    = 3'd1;
  localparam logic [2:0] CFG_PROCESS_INC  = 3'd2;
  localparam logic [2:0] CFG_MEAS_VAR     = 3'd3;

  // reset values
  localparam logic [23:0] TIME_STEP_RST = 24'd67109;
  localparam logic [27:0] PROC_INC_RST  = 28'd68719;
  localparam logic [23:0] MEAS_VAR_RST  = 24'd589824;
  localparam logic [31:0] VARIANCE_RST  = 32'd1073741824;

  // configuration registers
  typedef struct packed {
    logic signed [24:0] roll_offset;
    logic [23:0]        time_step;
    logic [27:0]        process_increment;
    logic [23:0]        measurement_variance;
  } cfg_t;

  // classified item passed from front to back
  typedef struct packed {
    logic signed [24:0] ax;
    logic signed [24:0] ay;
    logic signed [24:0] az;
    logic signed [15:0] gx;
    logic               zero_den;
  } q_item_t;

  // divider request
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [37:0] den;
  } div_req_t;

  // arctangent table in units of 2^-24 degree
  function automatic logic signed [31:0] atan_q24(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:  v = 32'sd754974720;
      5'd1:  v = 32'sd445687602;
      5'd2:  v = 32'sd235489088;
      5'd3:  v = 32'sd119537938;
      5'd4:  v = 32'sd60000934;
      5'd5:  v = 32'sd30029717;
      5'd6:  v = 32'sd15018523;
      5'd7:  v = 32'sd7509720;
      5'd8:  v = 32'sd3754917;
      5'd9:  v = 32'sd1877466;
      5'd10: v = 32'sd938734;
      5'd11: v = 32'sd469367;
      5'd12: v = 32'sd234684;
      5'd13: v = 32'sd117342;
      5'd14: v = 32'sd58671;
      5'd15: v = 32'sd29335;
      5'd16: v = 32'sd14668;
      5'd17: v = 32'sd7334;
      5'd18: v = 32'sd3667;
      5'd19: v = 32'sd1833;
      5'd20: v = 32'sd917;
      5'd21: v = 32'sd458;
      5'd22: v = 32'sd229;
      5'd23: v = 32'sd115;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // saturate to 25 bits signed
  function automatic logic signed [24:0] sat25(input logic signed [31:0] v);
    logic signed [24:0] r;
    if (v > 32'sd16777215) begin
      r = 25'sh0FFFFFF;
    end else if (v < -32'sd16777216) begin
      r = 25'sh1000000;
    end else begin
      r = v[24:0];
    end
    return r;
  endfunction

endpackage

// ===== src/roll_angle_kalman_filter.sv =====
// top level of the roll angle kalman filter
//
//  channel | signals                                      | direction
//  in      | in_valid in_ready accel_x accel_y accel_z gyro_x | sample items in
//  out     | out_valid out_ready roll_angle filtered_angle uncertainty | result items out
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data       | register writes in
//
// the back end works an item through 25 root steps, 16 cordic steps and a wait
// on the divider for the gain; an item with a zero denominator skips root and cordic.
// the front takes an item whenever the two entry queue has room.
// rst is synchronous; it clears the queue, the sequencer and the filter state.
// an untaken result stalls the back end at its next result; the queue keeps filling.
module roll_angle_kalman_filter import rakf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [24:0] roll_angle,
  output logic signed [24:0] filtered_angle,
  output logic [31:0]        uncertainty,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [27:0]        cfg_data
);

  cfg_t        cfg;
  q_item_t     push_item;
  q_item_t     pop_item;
  logic        q_push;
  logic        q_pop;
  logic        q_empty;
  logic        q_full;
  div_req_t    div_req;
  logic        div_done;
  logic [33:0] div_quot;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.roll_offset          <= 25'sd0;
      cfg.time_step            <= TIME_STEP_RST;
      cfg.process_increment    <= PROC_INC_RST;
      cfg.measurement_variance <= MEAS_VAR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROLL_OFFSET: cfg.roll_offset          <= cfg_data[24:0];
        CFG_TIME_STEP:   cfg.time_step            <= cfg_data[23:0];
        CFG_PROCESS_INC: cfg.process_increment    <= cfg_data;
        CFG_MEAS_VAR:    cfg.measurement_variance <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  rakf_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .accel_x  (accel_x),
    .accel_y  (accel_y),
    .accel_z  (accel_z),
    .gyro_x   (gyro_x),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  rakf_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  rakf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  rakf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .item           (pop_item),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .div_req        (div_req),
    .div_done       (div_done),
    .div_quot       (div_quot),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .roll_angle     (roll_angle),
    .filtered_angle (filtered_angle),
    .uncertainty    (uncertainty)
  );

`ifndef SYNTH
  // an accepted item is in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !q_empty)
    else $error("accepted item missing from queue");

  // the back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  // the divider never reports a result right after a start
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> !div_done)
    else $error("divider done right after start");
`endif

endmodule

// ===== src/rakf_front.sv =====
// front end: accepts raw samples, removes offsets and flags a zero denominator
module rakf_front import rakf_pkg::*; (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic               q_full,
  output logic               q_push,
  output q_item_t            q_item
);

  // take an item whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // scale to 2^-20 g and apply offsets
  always_comb begin
    q_item.ax = {accel_x[15], accel_x, 8'h00} - ACC_X_OFS;
    q_item.ay = {accel_y[15], accel_y, 8'h00} + ACC_Y_OFS;
    q_item.az = {accel_z[15], accel_z, 8'h00} - ACC_Z_OFS;
    q_item.gx = gyro_x;
    q_item.zero_den = (q_item.ay == 25'sd0) && (q_item.az == 25'sd0);
  end

endmodule

// ===== src/rakf_fifo.sv =====
// two entry queue between front and back
module rakf_fifo import rakf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t push_item,
  input  logic    pop,
  output q_item_t pop_item,
  output logic    empty,
  output logic    full
);

  q_item_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty    = (count == 2'd0);
  assign full     = (count == 2'd2);
  assign pop_item = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== src/rakf_div.sv =====
// restoring divider, one quotient bit per cycle, 34 bit quotient
module rakf_div import rakf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        done,
  output logic [33:0] quot
);

  logic        busy;
  logic [5:0]  cnt;
  logic [37:0] rem;
  logic [37:0] den;
  logic [33:0] q_sh;
  logic [37:0] trial;
  logic        ge;

  // shift in next dividend bit and compare
  assign trial = {rem[36:0], q_sh[33]};
  assign ge    = (trial >= den);
  assign quot  = q_sh;

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= {8'h00, req.num[63:34]};
      q_sh <= req.num[33:0];
      den  <= req.den;
    end else if (busy) begin
      rem  <= ge ? (trial - den) : trial;
      q_sh <= {q_sh[32:0], ge};
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 6'd0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd33;
        done <= 1'b0;
      end else if (busy) begin
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt  <= cnt - 6'd1;
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

// ===== src/rakf_back.sv =====
// back end: root, cordic, prediction, kalman update and result register
module rakf_back import rakf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  q_item_t             item,
  input  logic                q_empty,
  output logic                q_pop,
  output div_req_t            div_req,
  input  logic                div_done,
  input  logic [33:0]         div_quot,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [24:0]  roll_angle,
  output logic signed [24:0]  filtered_angle,
  output logic [31:0]         uncertainty
);

  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_SQ_Y       = 4'd1;
  localparam logic [3:0] ST_SQ_Z       = 4'd2;
  localparam logic [3:0] ST_ROOT       = 4'd3;
  localparam logic [3:0] ST_CORDIC     = 4'd4;
  localparam logic [3:0] ST_GYRO_MUL   = 4'd5;
  localparam logic [3:0] ST_GYRO_SCALE = 4'd6;
  localparam logic [3:0] ST_PREDICT    = 4'd7;
  localparam logic [3:0] ST_GAIN_DIV   = 4'd8;
  localparam logic [3:0] ST_GAIN_WAIT  = 4'd9;
  localparam logic [3:0] ST_MUL        = 4'd10;
  localparam logic [3:0] ST_UPDATE     = 4'd11;
  localparam logic [3:0] ST_OUT        = 4'd12;

  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);
  localparam logic [30:0] GAIN_ONE = 31'd1 << 30;

  logic [3:0]         state;
  q_item_t            it;
  logic signed [24:0] est;
  logic [31:0]        var_q;
  logic [31:0]        p;
  logic [36:0]        den;
  logic [47:0]        sq_y;
  logic [48:0]        v;
  logic [48:0]        r;
  logic [4:0]         k;
  logic signed [27:0] cx;
  logic signed [27:0] cy;
  logic signed [31:0] z;
  logic [4:0]         ci;
  logic signed [24:0] meas;
  logic signed [40:0] gprod;
  logic [63:0]        gyro_q;
  logic signed [27:0] pred;
  logic [30:0]        gain;
  logic signed [60:0] cprod;
  logic [62:0]        vprod;

  logic [32:0]        psum;
  logic signed [49:0] sq_a;
  logic signed [49:0] sq_b;
  logic [48:0]        root_bit;
  logic [48:0]        root_trial;
  logic               root_ge;
  logic [48:0]        r_next;
  logic signed [27:0] cx_sh;
  logic signed [27:0] cy_sh;
  logic signed [31:0] z_next;
  logic signed [31:0] z_rnd;
  logic [40:0]        gmag;
  logic [31:0]        gyro_m;
  logic signed [28:0] diff;
  logic [60:0]        cmag;
  logic [30:0]        corr_q;
  logic signed [31:0] corr;
  logic signed [31:0] est_sum;
  logic signed [25:0] roll_diff;

  // arithmetic helpers
  always_comb begin
    psum       = {1'b0, var_q} + {5'b0, cfg.process_increment};
    sq_a       = it.ay * it.ay;
    sq_b       = it.az * it.az;
    root_bit   = 49'd1 << {k, 1'b0};
    root_trial = r + root_bit;
    root_ge    = (v >= root_trial);
    r_next     = root_ge ? ((r >> 1) + root_bit) : (r >> 1);
    cx_sh      = cx >>> ci;
    cy_sh      = cy >>> ci;
    z_next     = cy[27] ? (z - atan_q24(ci)) : (z + atan_q24(ci));
    z_rnd      = (z_next + MEAS_RND) >>> MEAS_SHIFT;
    gmag       = gprod[40] ? 41'(-gprod) : 41'(gprod);
    gyro_m     = 32'((gmag + GYRO_RND) >> GYRO_SHIFT);
    diff       = {{4{meas[24]}}, meas} - {pred[27], pred};
    cmag       = cprod[60] ? 61'(-cprod) : 61'(cprod);
    corr_q     = 31'((cmag + 61'(1 << 29)) >> 30);
    corr       = cprod[60] ? -$signed({1'b0, corr_q}) : $signed({1'b0, corr_q});
    est_sum    = $signed({{4{pred[27]}}, pred}) + corr;
    roll_diff  = {est[24], est} - {cfg.roll_offset[24], cfg.roll_offset};
  end

  // gain division request
  always_comb begin
    div_req.start = (state == ST_GAIN_DIV) && (den != 37'd0);
    div_req.num   = {2'b00, p, 30'd0} + 64'(den >> 1);
    div_req.den   = {1'b0, den};
  end

  assign q_pop = (state == ST_IDLE) && !q_empty;

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        it <= item;
        p  <= psum[32] ? 32'hFFFF_FFFF : psum[31:0];
      end
      ST_SQ_Y: begin
        sq_y <= sq_a[47:0];
        den  <= {5'b0, p} + {1'b0, cfg.measurement_variance, 12'd0};
      end
      ST_SQ_Z: begin
        v <= {1'b0, sq_y} + sq_b[48:0];
        r <= 49'd0;
        k <= 5'd24;
        if (it.ax > 25'sd0) begin
          meas <= ANGLE_90;
        end else if (it.ax < 25'sd0) begin
          meas <= -ANGLE_90;
        end else begin
          meas <= 25'sd0;
        end
      end
      ST_ROOT: begin
        if (root_ge) begin
          v <= v - root_trial;
        end
        r  <= r_next;
        k  <= k - 5'd1;
        cx <= r_next[27:0];
        cy <= {{3{it.ax[24]}}, it.ax};
        z  <= 32'sd0;
        ci <= 5'd0;
      end
      ST_CORDIC: begin
        cx   <= cy[27] ? (cx - cy_sh) : (cx + cy_sh);
        cy   <= cy[27] ? (cy + cx_sh) : (cy - cx_sh);
        z    <= z_next;
        ci   <= ci + 5'd1;
        meas <= z_rnd[24:0];
      end
      ST_GYRO_MUL: begin
        gprod <= $signed({1'b0, cfg.time_step}) * it.gx;
      end
      // divide by 131 through the reciprocal
      ST_GYRO_SCALE: begin
        gyro_q <= gyro_m * GYRO_RCP;
      end
      ST_PREDICT: begin
        pred <= gprod[40]
              ? ($signed({{3{est[24]}}, est})
                 - $signed({3'b000, gyro_q[63:GYRO_RCP_SHIFT]}))
              : ($signed({{3{est[24]}}, est})
                 + $signed({3'b000, gyro_q[63:GYRO_RCP_SHIFT]}));
        gain <= 31'd0;
      end
      ST_GAIN_WAIT: begin
        gain <= div_quot[30:0];
      end
      ST_MUL: begin
        cprod <= $signed({1'b0, gain}) * diff;
        vprod <= p * (GAIN_ONE - gain);
      end
      default: begin
      end
    endcase
  end

  // sequencer, filter state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      est       <= 25'sd0;
      var_q     <= VARIANCE_RST;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_SQ_Y;
          end
        end
        ST_SQ_Y: begin
          state <= ST_SQ_Z;
        end
        ST_SQ_Z: begin
          state <= it.zero_den ? ST_GYRO_MUL : ST_ROOT;
        end
        ST_ROOT: begin
          if (k == 5'd0) begin
            state <= ST_CORDIC;
          end
        end
        ST_CORDIC: begin
          if (ci == LAST_STEP) begin
            state <= ST_GYRO_MUL;
          end
        end
        ST_GYRO_MUL: begin
          state <= ST_GYRO_SCALE;
        end
        ST_GYRO_SCALE: begin
          state <= ST_PREDICT;
        end
        ST_PREDICT: begin
          state <= ST_GAIN_DIV;
        end
        ST_GAIN_DIV: begin
          state <= (den == 37'd0) ? ST_MUL : ST_GAIN_WAIT;
        end
        ST_GAIN_WAIT: begin
          if (div_done) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          est   <= sat25(est_sum);
          var_q <= 32'((vprod + 63'(1 << 29)) >> 30);
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            roll_angle     <= sat25({{6{roll_diff[25]}}, roll_diff});
            filtered_angle <= est;
            uncertainty    <= var_q;
            out_valid      <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
